// ----- rtl/csf_pkg.sv -----
// Shared constants, types and sequencer states of the crossing span filter.
`default_nettype none
package csf_pkg;

  localparam int MaxSpans = 64;
  localparam int IdxW     = $clog2(MaxSpans);
  localparam int CntW     = IdxW + 1;
  localparam int PosW     = 6;
  localparam int LenW     = 7;
  localparam int EndW     = 8;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [LenW-1:0] len;
  } span_t;

  typedef struct packed {
    logic [PosW-1:0] beg;
    logic [EndW-1:0] fin;
    logic            killed;
  } stack_t;

  typedef struct packed {
    logic            drop;
    logic [IdxW-1:0] idx;
  } order_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_I,
    ST_GET_I,
    ST_SWEEP,
    ST_RANK_WR,
    ST_P_ORD,
    ST_P_SPAN,
    ST_P_EVAL,
    ST_P_POP,
    ST_P_POPW,
    ST_O_ORD,
    ST_O_SPAN,
    ST_O_EMIT
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/csf_ram.sv -----
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module csf_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write one word, read one word through a registered output
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/crossing_span_filter.sv -----
// Top level: span load, rank sort, nesting stack pass and survivor output.
//
// Channel  Direction  Handshake         Payload
// input    in         start_i & !busy_o start_pos_i, span_len_i, last_in_i
// result   out        valid_o strobe    source_index_o, kept_pos_o, kept_span_o, last_out_o
//
// Spans load one per cycle while busy_o is low. The closing span starts a burst:
// the rank sort sweeps the span store once per span, the stack pass takes each
// span in rank order (unit spans skip the stack, longer spans pop the entries
// that end before they do and are then pushed), and the output sweep emits each
// survivor and skips each dropped span. Every step is set by the one read port
// of each RAM.
// Reset clears the sequencer and counters; the RAMs hold no reset value.
// Results cannot be stalled: each one shows on valid_o for a single cycle.
`default_nettype none
module crossing_span_filter (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [5:0] start_pos_i,
  input  wire logic [6:0] span_len_i,
  input  wire logic       last_in_i,
  output logic            valid_o,
  output logic [5:0]      source_index_o,
  output logic [5:0]      kept_pos_o,
  output logic [6:0]      kept_span_o,
  output logic            last_out_o
);

  localparam int IdxW = csf_pkg::IdxW;
  localparam int CntW = csf_pkg::CntW;

  csf_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] j_q, j_d;
  logic [IdxW-1:0] jc_q, jc_d;
  logic            cmp_v_q, cmp_v_d;
  logic [IdxW-1:0] rank_q, rank_d;
  csf_pkg::span_t  key_q, key_d;
  logic [CntW-1:0] k_q, k_d;
  logic [IdxW-1:0] idx_q, idx_d;
  csf_pkg::span_t  cur_q, cur_d;
  logic            kill_q, kill_d;
  logic [CntW-1:0] depth_q, depth_d;
  csf_pkg::stack_t top_q, top_d;
  logic [CntW-1:0] total_q, total_d;
  logic [CntW-1:0] emit_q, emit_d;
  logic            valid_q, valid_d;
  logic [5:0]      oidx_q, oidx_d;
  csf_pkg::span_t  ospan_q, ospan_d;
  logic            olast_q, olast_d;

  // RAM ports
  logic            st_we;
  logic [IdxW-1:0] st_waddr, st_raddr;
  csf_pkg::span_t  st_wdata, st_rdata;
  logic            or_we;
  logic [IdxW-1:0] or_waddr, or_raddr;
  csf_pkg::order_t or_wdata, or_rdata;
  logic            sk_we;
  logic [IdxW-1:0] sk_waddr, sk_raddr;
  csf_pkg::stack_t sk_wdata, sk_rdata;

  logic [csf_pkg::EndW-1:0] cur_end;
  logic                     goes_first;
  logic [CntW-1:0]          k_inc;

  csf_ram #(.Width($bits(csf_pkg::span_t)), .Depth(csf_pkg::MaxSpans)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  csf_ram #(.Width($bits(csf_pkg::order_t)), .Depth(csf_pkg::MaxSpans)) u_order (
    .clk_i, .we_i(or_we), .waddr_i(or_waddr), .wdata_i(or_wdata),
    .raddr_i(or_raddr), .rdata_o(or_rdata)
  );

  csf_ram #(.Width($bits(csf_pkg::stack_t)), .Depth(csf_pkg::MaxSpans)) u_stack (
    .clk_i, .we_i(sk_we), .waddr_i(sk_waddr), .wdata_i(sk_wdata),
    .raddr_i(sk_raddr), .rdata_o(sk_rdata)
  );

  // span end and stable ordering compare
  assign cur_end = {2'b00, cur_q.pos} + {1'b0, cur_q.len};
  assign goes_first = (st_rdata.pos < key_q.pos) ||
                      ((st_rdata.pos == key_q.pos) &&
                       ((st_rdata.len > key_q.len) ||
                        ((st_rdata.len == key_q.len) && (jc_q < i_q[IdxW-1:0]))));
  assign k_inc = k_q + CntW'(1);

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    i_d     = i_q;
    j_d     = j_q;
    jc_d    = jc_q;
    cmp_v_d = 1'b0;
    rank_d  = rank_q;
    key_d   = key_q;
    k_d     = k_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    kill_d  = kill_q;
    depth_d = depth_q;
    top_d   = top_q;
    total_d = total_q;
    emit_d  = emit_q;
    valid_d = 1'b0;
    oidx_d  = oidx_q;
    ospan_d = ospan_q;
    olast_d = olast_q;
    st_we    = 1'b0;
    st_waddr = cnt_q[IdxW-1:0];
    st_wdata = '{pos: start_pos_i, len: span_len_i};
    st_raddr = i_q[IdxW-1:0];
    or_we    = 1'b0;
    or_waddr = rank_q;
    or_wdata = '{drop: 1'b0, idx: i_q[IdxW-1:0]};
    or_raddr = k_q[IdxW-1:0];
    sk_we    = 1'b0;
    sk_waddr = depth_q[IdxW-1:0];
    sk_wdata = '{beg: cur_q.pos, fin: cur_end, killed: kill_q};
    sk_raddr = IdxW'(depth_q - CntW'(2));

    case (state_q)
      csf_pkg::ST_IDLE: begin
        if (start_i) begin
          if (cnt_q < CntW'(csf_pkg::MaxSpans)) begin
            st_we = 1'b1;
            cnt_d = cnt_q + CntW'(1);
          end
          if (last_in_i) begin
            i_d     = '0;
            state_d = csf_pkg::ST_RD_I;
          end
        end
      end
      csf_pkg::ST_RD_I: begin
        st_raddr = i_q[IdxW-1:0];
        state_d  = csf_pkg::ST_GET_I;
      end
      csf_pkg::ST_GET_I: begin
        key_d   = st_rdata;
        j_d     = '0;
        rank_d  = '0;
        state_d = csf_pkg::ST_SWEEP;
      end
      csf_pkg::ST_SWEEP: begin
        // count spans that sort ahead of span i
        if (cmp_v_q && goes_first) begin
          rank_d = rank_q + IdxW'(1);
        end
        st_raddr = j_q[IdxW-1:0];
        if (j_q < cnt_q) begin
          cmp_v_d = 1'b1;
          jc_d    = j_q[IdxW-1:0];
          j_d     = j_q + CntW'(1);
        end else begin
          state_d = csf_pkg::ST_RANK_WR;
        end
      end
      csf_pkg::ST_RANK_WR: begin
        or_we = 1'b1;
        i_d   = i_q + CntW'(1);
        if (i_q + CntW'(1) == cnt_q) begin
          k_d     = '0;
          depth_d = '0;
          total_d = '0;
          state_d = csf_pkg::ST_P_ORD;
        end else begin
          state_d = csf_pkg::ST_RD_I;
        end
      end
      csf_pkg::ST_P_ORD: begin
        or_raddr = k_q[IdxW-1:0];
        state_d  = csf_pkg::ST_P_SPAN;
      end
      csf_pkg::ST_P_SPAN: begin
        st_raddr = or_rdata.idx;
        idx_d    = or_rdata.idx;
        state_d  = csf_pkg::ST_P_EVAL;
      end
      csf_pkg::ST_P_EVAL: begin
        cur_d = st_rdata;
        if (st_rdata.len == csf_pkg::LenW'(1)) begin
          // unit spans skip the stack and always survive
          or_we    = 1'b1;
          or_waddr = k_q[IdxW-1:0];
          or_wdata = '{drop: 1'b0, idx: idx_q};
          total_d  = total_q + CntW'(1);
          k_d      = k_inc;
          state_d  = (k_inc == cnt_q) ? csf_pkg::ST_O_ORD : csf_pkg::ST_P_ORD;
          if (k_inc == cnt_q) begin
            k_d    = '0;
            emit_d = '0;
          end
        end else begin
          kill_d = (depth_q != '0) && top_q.killed && (st_rdata.pos == top_q.beg) &&
                   (({2'b00, st_rdata.pos} + {1'b0, st_rdata.len}) == top_q.fin);
          state_d = csf_pkg::ST_P_POP;
        end
      end
      csf_pkg::ST_P_POP: begin
        if ((depth_q != '0) && (cur_end > top_q.fin)) begin
          // pop an entry that ends before the span does; drop on a partial cross
          if ({2'b00, cur_q.pos} < top_q.fin) begin
            kill_d = 1'b1;
          end
          depth_d  = depth_q - CntW'(1);
          sk_raddr = IdxW'(depth_q - CntW'(2));
          if (depth_q > CntW'(1)) begin
            state_d = csf_pkg::ST_P_POPW;
          end
        end else begin
          // push and record the verdict
          sk_we    = 1'b1;
          top_d    = sk_wdata;
          depth_d  = depth_q + CntW'(1);
          or_we    = 1'b1;
          or_waddr = k_q[IdxW-1:0];
          or_wdata = '{drop: kill_q, idx: idx_q};
          total_d  = total_q + CntW'(!kill_q);
          k_d      = k_inc;
          state_d  = (k_inc == cnt_q) ? csf_pkg::ST_O_ORD : csf_pkg::ST_P_ORD;
          if (k_inc == cnt_q) begin
            k_d    = '0;
            emit_d = '0;
          end
        end
      end
      csf_pkg::ST_P_POPW: begin
        top_d   = sk_rdata;
        state_d = csf_pkg::ST_P_POP;
      end
      csf_pkg::ST_O_ORD: begin
        or_raddr = k_q[IdxW-1:0];
        state_d  = csf_pkg::ST_O_SPAN;
      end
      csf_pkg::ST_O_SPAN: begin
        st_raddr = or_rdata.idx;
        idx_d    = or_rdata.idx;
        if (or_rdata.drop) begin
          k_d = k_inc;
          if (k_inc == cnt_q) begin
            cnt_d   = '0;
            state_d = csf_pkg::ST_IDLE;
          end else begin
            state_d = csf_pkg::ST_O_ORD;
          end
        end else begin
          state_d = csf_pkg::ST_O_EMIT;
        end
      end
      csf_pkg::ST_O_EMIT: begin
        valid_d = 1'b1;
        oidx_d  = 6'(idx_q);
        ospan_d = st_rdata;
        olast_d = (emit_q + CntW'(1) == total_q);
        emit_d  = emit_q + CntW'(1);
        k_d     = k_inc;
        if (k_inc == cnt_q) begin
          cnt_d   = '0;
          state_d = csf_pkg::ST_IDLE;
        end else begin
          state_d = csf_pkg::ST_O_ORD;
        end
      end
      default: begin
        state_d = csf_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csf_pkg::ST_IDLE;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      cmp_v_q <= 1'b0;
      k_q     <= '0;
      depth_q <= '0;
      total_q <= '0;
      emit_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
      cmp_v_q <= cmp_v_d;
      k_q     <= k_d;
      depth_q <= depth_d;
      total_q <= total_d;
      emit_q  <= emit_d;
      valid_q <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    jc_q    <= jc_d;
    rank_q  <= rank_d;
    key_q   <= key_d;
    idx_q   <= idx_d;
    cur_q   <= cur_d;
    kill_q  <= kill_d;
    top_q   <= top_d;
    oidx_q  <= oidx_d;
    ospan_q <= ospan_d;
    olast_q <= olast_d;
  end

  assign busy_o         = (state_q != csf_pkg::ST_IDLE);
  assign valid_o        = valid_q;
  assign source_index_o = oidx_q;
  assign kept_pos_o     = ospan_q.pos;
  assign kept_span_o    = ospan_q.len;
  assign last_out_o     = olast_q;

endmodule
`default_nettype wire
